/* hw/rtl/zcpsm_pkg.sv */
// ----------------------------------------------------------------------------
// zcpsm_pkg
// shared types, register map and event codes of the zero-cross pulse-skip
// modulator
// ----------------------------------------------------------------------------
package zcpsm_pkg;

   localparam int LevelWidth   = 16;
   localparam int AccWidth     = 17;
   localparam int TimeWidth    = 32;
   localparam int RunWidth     = 32;
   localparam int DivWidth     = 8;
   localparam int GapWidth     = 8;
   localparam int KindWidth    = 2;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 4;

   // event kinds
   localparam logic [KindWidth-1:0] KIND_CROSSING  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_SET_LEVEL = 2'd1;
   localparam logic [KindWidth-1:0] KIND_CLEAR_RUN = 2'd2;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_FULL_SCALE = 2'd0;
   localparam logic [1:0] REG_DIVIDER    = 2'd1;
   localparam logic [1:0] REG_MIN_GAP    = 2'd2;

   localparam logic [LevelWidth-1:0] FULL_SCALE_RESET = 16'd100;
   localparam logic [DivWidth-1:0]   DIVIDER_RESET    = 8'd1;
   localparam logic [GapWidth-1:0]   MIN_GAP_RESET    = 8'd0;

   typedef struct packed {
      logic [LevelWidth-1:0] full_scale;
      logic [DivWidth-1:0]   crossing_divider;
      logic [GapWidth-1:0]   min_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [LevelWidth-1:0] level;
      logic [TimeWidth-1:0]  time_ms;
   } req_item_type;

   typedef struct packed {
      logic                drive;
      logic                decided;
      logic                filtered;
      logic [RunWidth-1:0] on_run;
   } rsp_item_type;

endpackage

/* hw/rtl/zcpsm_req_if.sv */
// ----------------------------------------------------------------------------
// zcpsm_req_if
// event channel: valid/ready handshake with kind, level and timestamp
// ----------------------------------------------------------------------------
interface zcpsm_req_if;
   import zcpsm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KindWidth-1:0]  kind;
   logic [LevelWidth-1:0] level;
   logic [TimeWidth-1:0]  time_ms;

   modport source (output valid, kind, level, time_ms, input ready);
   modport sink   (input valid, kind, level, time_ms, output ready);
endinterface

/* hw/rtl/zcpsm_rsp_if.sv */
// ----------------------------------------------------------------------------
// zcpsm_rsp_if
// result channel: valid/ready handshake with drive state and status
// ----------------------------------------------------------------------------
interface zcpsm_rsp_if;
   import zcpsm_pkg::*;

   logic                valid;
   logic                ready;
   logic                drive;
   logic                decided;
   logic                filtered;
   logic [RunWidth-1:0] on_run;

   modport source (output valid, drive, decided, filtered, on_run, input ready);
   modport sink   (input valid, drive, decided, filtered, on_run, output ready);
endinterface

/* hw/rtl/zcpsm_csr.sv */
// ----------------------------------------------------------------------------
// zcpsm_csr
// apb register file: full scale, crossing divider, minimum gap
// ----------------------------------------------------------------------------
module zcpsm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [zcpsm_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [zcpsm_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [zcpsm_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                 pready,
   output zcpsm_pkg::cfg_type                   cfg
);
   import zcpsm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FULL_SCALE: cfg_in.full_scale       = pwdata[LevelWidth-1:0];
            REG_DIVIDER:    cfg_in.crossing_divider = pwdata[DivWidth-1:0];
            REG_MIN_GAP:    cfg_in.min_gap_ms       = pwdata[GapWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale       <= FULL_SCALE_RESET;
         cfg_ff.crossing_divider <= DIVIDER_RESET;
         cfg_ff.min_gap_ms       <= MIN_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FULL_SCALE: prdata = {{(CsrDataWidth-LevelWidth){1'b0}}, cfg_ff.full_scale};
         REG_DIVIDER:    prdata = {{(CsrDataWidth-DivWidth){1'b0}}, cfg_ff.crossing_divider};
         REG_MIN_GAP:    prdata = {{(CsrDataWidth-GapWidth){1'b0}}, cfg_ff.min_gap_ms};
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

/* hw/rtl/zcpsm_core.sv */
// ----------------------------------------------------------------------------
// zcpsm_core
// modulator state and one-event update: gap filter, divider, accumulator
// ----------------------------------------------------------------------------
module zcpsm_core (
   input  logic                      clock,
   input  logic                      reset,
   input  zcpsm_pkg::cfg_type        cfg,
   input  logic                      step_en,
   input  zcpsm_pkg::req_item_type   item,
   output zcpsm_pkg::rsp_item_type   result
);
   import zcpsm_pkg::*;

   logic [AccWidth-1:0]   acc_ff,   acc_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic [RunWidth-1:0]   run_ff,   run_in;
   logic [DivWidth-1:0]   divc_ff,  divc_in;
   logic [TimeWidth-1:0]  last_ff,  last_in;
   logic                  drive_ff, drive_in;

   logic [TimeWidth-1:0]  gap_diff;
   logic                  too_close;
   logic [DivWidth-1:0]   div_eff;
   logic                  take_decision;
   logic [AccWidth:0]     acc_sum;
   logic [AccWidth-1:0]   acc_wrap;
   logic [AccWidth-1:0]   acc_sub;
   logic [AccWidth-1:0]   fs_ext;
   logic                  overflow;
   logic                  skip;
   logic [LevelWidth-1:0] level_clamp;
   logic                  decided;
   logic                  filtered;

   assign fs_ext    = {1'b0, cfg.full_scale};
   assign gap_diff  = item.time_ms - last_ff;
   assign too_close = (cfg.min_gap_ms != '0) &&
                      (gap_diff < {{(TimeWidth-GapWidth){1'b0}}, cfg.min_gap_ms});
   assign div_eff   = (cfg.crossing_divider == '0) ? DivWidth'(1) : cfg.crossing_divider;
   assign take_decision = (divc_ff >= div_eff);

   // accumulator step, kept modulo full scale
   assign acc_sum  = {1'b0, acc_ff} + {{(AccWidth-LevelWidth+1){1'b0}}, level_ff};
   assign acc_wrap = acc_sum[AccWidth-1:0];
   assign overflow = (acc_wrap >= fs_ext);
   assign acc_sub  = overflow ? (acc_wrap - fs_ext) : acc_wrap;

   assign level_clamp = (item.level < cfg.full_scale) ? item.level : cfg.full_scale;

   always_comb begin
      acc_in   = acc_ff;
      level_in = level_ff;
      run_in   = run_ff;
      divc_in  = divc_ff;
      last_in  = last_ff;
      drive_in = drive_ff;
      decided  = 1'b0;
      filtered = 1'b0;
      skip     = 1'b0;
      case (item.kind)
         KIND_CROSSING: begin
            if (too_close) begin
               filtered = 1'b1;
            end else begin
               last_in = item.time_ms;
               if (take_decision) begin
                  divc_in = DivWidth'(1);
                  decided = 1'b1;
                  skip    = !overflow;
                  acc_in  = acc_sub;
                  // residue still past full scale: dump it and fire
                  if (acc_sub > fs_ext) begin
                     acc_in = '0;
                     skip   = 1'b0;
                  end
                  // keep whole waves: no skip on an odd run
                  if (run_ff[0]) begin
                     skip = 1'b0;
                  end
                  if (skip) begin
                     run_in   = '0;
                     drive_in = 1'b0;
                  end else begin
                     run_in   = run_ff + RunWidth'(1);
                     drive_in = 1'b1;
                  end
               end else begin
                  divc_in = divc_ff + DivWidth'(1);
               end
            end
         end
         KIND_SET_LEVEL: begin
            level_in = level_clamp;
            if (level_clamp == '0) begin
               drive_in = 1'b0;
            end
         end
         KIND_CLEAR_RUN: begin
            run_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         level_ff <= '0;
         run_ff   <= '0;
         divc_ff  <= '0;
         last_ff  <= '0;
         drive_ff <= 1'b0;
      end else if (step_en) begin
         acc_ff   <= acc_in;
         level_ff <= level_in;
         run_ff   <= run_in;
         divc_ff  <= divc_in;
         last_ff  <= last_in;
         drive_ff <= drive_in;
      end
   end

   assign result.drive    = drive_in;
   assign result.decided  = decided;
   assign result.filtered = filtered;
   assign result.on_run   = run_in;
endmodule

/* hw/rtl/zero_cross_pulse_skip_modulator.sv */
// ----------------------------------------------------------------------------
// zero_cross_pulse_skip_modulator
// pulse-skip power control on mains zero crossings, one result beat per event
// ----------------------------------------------------------------------------
// an accepted event beat passes the input register, then the result register, to rsp_chan
// throughput: one event per cycle while rsp_chan is not stalled, set by the
// state update between the input register and the result register
// reset: synchronous, active high; clears all modulator state and empties both
// pipeline registers, registers return to full scale 100, divider 1, gap 0
// ----------------------------------------------------------------------------
module zero_cross_pulse_skip_modulator (
   input  logic                               clock,
   input  logic                               reset,
   zcpsm_req_if.sink                          req_chan,
   zcpsm_rsp_if.source                        rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [zcpsm_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [zcpsm_pkg::CsrDataWidth-1:0] pwdata,
   output logic [zcpsm_pkg::CsrDataWidth-1:0] prdata,
   output logic                               pready
);
   import zcpsm_pkg::*;

   cfg_type      cfg;

   // input register: holds one accepted event beat
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff,  in_item_in;

   // result register: holds one finished result beat
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff,  out_item_in;

   rsp_item_type core_result;
   logic         advance;
   logic         req_fire;

   // the held event moves on whenever the result register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in        = 1'b1;
         in_item_in.kind    = req_chan.kind;
         in_item_in.level   = req_chan.level;
         in_item_in.time_ms = req_chan.time_ms;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   zcpsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // state update happens on the cycle the event leaves the input register
   zcpsm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (core_result)
   );

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.drive    = out_item_ff.drive;
   assign rsp_chan.decided  = out_item_ff.decided;
   assign rsp_chan.filtered = out_item_ff.filtered;
   assign rsp_chan.on_run   = out_item_ff.on_run;
endmodule

/* verif/zcpsm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zcpsm_checker
// watches the event, result and register ports, keeps its own model of the
// pulse-skip modulator and compares every result beat in order
// ----------------------------------------------------------------------------
module zcpsm_checker (
   input  logic                               clock,
   input  logic                               reset,
   zcpsm_req_if                               req_mon,
   zcpsm_rsp_if                               rsp_mon,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [zcpsm_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [zcpsm_pkg::CsrDataWidth-1:0] pwdata,
   input  logic                               pready,
   output int                                 pending_beats,
   output int                                 mismatch_count
);
   import zcpsm_pkg::*;

   cfg_type               cfg;
   logic [AccWidth-1:0]   acc;
   logic [LevelWidth-1:0] level;
   logic [RunWidth-1:0]   run;
   logic [DivWidth-1:0]   div_count;
   logic [TimeWidth-1:0]  last_ms;
   logic                  drive;

   rsp_item_type          outcome_q[$];
   req_item_type          seen_event;
   rsp_item_type          predicted;
   rsp_item_type          wanted;

   initial mismatch_count = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // one event through the modulator, returns the state it reports
   function automatic void apply_event(input req_item_type ev, output rsp_item_type res);
      logic [DivWidth-1:0] div_limit;
      logic [AccWidth:0]   sum;
      logic [AccWidth-1:0] fs_wide;
      logic                fire;
      res = '0;
      fs_wide = AccWidth'(cfg.full_scale);
      case (ev.kind)
         KIND_CROSSING: begin
            if (cfg.min_gap_ms != '0 &&
                (ev.time_ms - last_ms) < TimeWidth'(cfg.min_gap_ms)) begin
               res.filtered = 1'b1;
            end else begin
               div_limit = (cfg.crossing_divider == '0) ? DivWidth'(1) : cfg.crossing_divider;
               last_ms = ev.time_ms;
               if (div_count >= div_limit) begin
                  div_count = DivWidth'(1);
                  res.decided = 1'b1;
                  sum = {1'b0, acc} + (AccWidth+1)'(level);
                  acc = sum[AccWidth-1:0];
                  fire = 1'b0;
                  if (acc >= fs_wide) begin
                     acc = acc - fs_wide;
                     fire = 1'b1;
                  end
                  if (acc > fs_wide) begin
                     acc = '0;
                     fire = 1'b1;
                  end
                  // odd on-run keeps the wave whole
                  if (!fire && run[0]) fire = 1'b1;
                  if (fire) begin
                     run = run + RunWidth'(1);
                     drive = 1'b1;
                  end else begin
                     run = '0;
                     drive = 1'b0;
                  end
               end else begin
                  div_count = div_count + DivWidth'(1);
               end
            end
         end
         KIND_SET_LEVEL: begin
            level = (ev.level < cfg.full_scale) ? ev.level : cfg.full_scale;
            if (level == '0) drive = 1'b0;
         end
         KIND_CLEAR_RUN: begin
            run = '0;
         end
         default: ;
      endcase
      res.drive  = drive;
      res.on_run = run;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.full_scale       = FULL_SCALE_RESET;
         cfg.crossing_divider = DIVIDER_RESET;
         cfg.min_gap_ms       = MIN_GAP_RESET;
         acc       = '0;
         level     = '0;
         run       = '0;
         div_count = '0;
         last_ms   = '0;
         drive     = 1'b0;
         outcome_q.delete();
         pending_beats <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_FULL_SCALE: cfg.full_scale       = pwdata[LevelWidth-1:0];
               REG_DIVIDER:    cfg.crossing_divider = pwdata[DivWidth-1:0];
               REG_MIN_GAP:    cfg.min_gap_ms       = pwdata[GapWidth-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            seen_event.kind    = req_mon.kind;
            seen_event.level   = req_mon.level;
            seen_event.time_ms = req_mon.time_ms;
            apply_event(seen_event, predicted);
            outcome_q.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("result beat with no event pending, on_run %0d",
                                         rsp_mon.on_run));
            end else begin
               wanted = outcome_q.pop_front();
               if (rsp_mon.drive !== wanted.drive)
                  report_mismatch($sformatf("drive got %b want %b",
                                            rsp_mon.drive, wanted.drive));
               if (rsp_mon.decided !== wanted.decided)
                  report_mismatch($sformatf("decided got %b want %b",
                                            rsp_mon.decided, wanted.decided));
               if (rsp_mon.filtered !== wanted.filtered)
                  report_mismatch($sformatf("filtered got %b want %b",
                                            rsp_mon.filtered, wanted.filtered));
               if (rsp_mon.on_run !== wanted.on_run)
                  report_mismatch($sformatf("on_run got %0d want %0d",
                                            rsp_mon.on_run, wanted.on_run));
            end
         end
         pending_beats <= outcome_q.size();
      end
   end

endmodule

/* verif/zero_cross_pulse_skip_modulator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zero_cross_pulse_skip_modulator_test
// drives crossing, level and clear events with random gaps and result stalls,
// walks the registers through several settings and lets the checker compare
// ----------------------------------------------------------------------------
module zero_cross_pulse_skip_modulator_test;
   import zcpsm_pkg::*;

   // event code the block ignores
   localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   int                      pending_beats;
   int                      mismatch_count;

   // timestamp of the mains as seen by the event source
   logic [TimeWidth-1:0]    mains_ms;
   // settings in force, used to aim levels and timestamps
   logic [LevelWidth-1:0]   scale_now;
   logic [GapWidth-1:0]     gap_now;
   // stretches with no idling on either side
   bit                      no_idle;
   int                      beats_sent;

   zcpsm_req_if req_chan ();
   zcpsm_rsp_if rsp_chan ();

   zero_cross_pulse_skip_modulator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   zcpsm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .pending_beats  (pending_beats),
      .mismatch_count (mismatch_count)
   );

   always #4 clock = ~clock;

   // one event beat, after a random hold-off; valid stays high on return
   task automatic send_event(input logic [KindWidth-1:0] kind,
                             input logic [LevelWidth-1:0] lvl,
                             input logic [TimeWidth-1:0] stamp);
      int hold;
      hold = no_idle ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
         req_chan.valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.level   <= lvl;
      req_chan.time_ms <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      beats_sent++;
      // now and then switch to back-to-back traffic for a while
      if (beats_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
   endtask

   // apb write: setup phase, access phase, then idle
   task automatic write_reg(input logic [1:0] idx, input logic [CsrDataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every result beat, then cover the pipeline latency
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase(input logic [LevelWidth-1:0] scale,
                            input logic [DivWidth-1:0] divider,
                            input logic [GapWidth-1:0] gap);
      settle();
      write_reg(REG_FULL_SCALE, CsrDataWidth'(scale));
      write_reg(REG_DIVIDER, CsrDataWidth'(divider));
      write_reg(REG_MIN_GAP, CsrDataWidth'(gap));
      scale_now = scale;
      gap_now   = gap;
   endtask

   // mostly crossings spaced around the gap setting, with level writes,
   // clears, unused codes and the odd jump or step back in time
   task automatic random_event();
      int                    pick;
      int                    shape;
      logic [LevelWidth-1:0] lvl;
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         shape = $urandom_range(0, 99);
         if (shape < 85)
            mains_ms = mains_ms + $urandom_range(0, 2 * int'(gap_now) + 6);
         else if (shape < 95)
            mains_ms = $urandom;
         else
            mains_ms = mains_ms - $urandom_range(1, 300);
         send_event(KIND_CROSSING, LevelWidth'($urandom), mains_ms);
      end else if (pick < 88) begin
         shape = $urandom_range(0, 9);
         if (shape < 5)
            lvl = LevelWidth'($urandom_range(0, int'(scale_now)));
         else if (shape < 6)
            lvl = '0;
         else if (shape < 8)
            lvl = LevelWidth'($urandom_range(int'(scale_now), 16'hFFFF));
         else
            lvl = LevelWidth'($urandom);
         send_event(KIND_SET_LEVEL, lvl, $urandom);
      end else if (pick < 94) begin
         send_event(KIND_CLEAR_RUN, LevelWidth'($urandom), $urandom);
      end else begin
         send_event(KIND_UNUSED, LevelWidth'($urandom), $urandom);
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) random_event();
   endtask

   // result side: random stall before each beat, none in no-idle stretches
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   initial begin
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.kind    <= KIND_CROSSING;
      req_chan.level   <= '0;
      req_chan.time_ms <= '0;
      scale_now  = FULL_SCALE_RESET;
      gap_now    = MIN_GAP_RESET;
      mains_ms   = '0;
      no_idle    = 1'b0;
      beats_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: scale 100, divider 1, no gap filter
      send_event(KIND_CROSSING, 16'd0, 32'd5);            // first crossing only counts
      send_event(KIND_SET_LEVEL, 16'd0, 32'd0);           // zero level, drive stays off
      send_event(KIND_SET_LEVEL, 16'hFFFF, 32'hFFFF_FFFF);// clamps to full scale
      send_event(KIND_CROSSING, 16'd0, 32'd15);           // full level fires
      send_event(KIND_SET_LEVEL, 16'd30, 32'd0);
      send_event(KIND_CROSSING, 16'd0, 32'd25);           // skip turned to fire, odd run
      send_event(KIND_CROSSING, 16'd0, 32'd35);           // real skip
      send_event(KIND_CROSSING, 16'd0, 32'd45);           // skip again
      send_event(KIND_CROSSING, 16'd0, 32'd55);           // accumulator overflow fires
      send_event(KIND_CLEAR_RUN, 16'd0, 32'd60);
      send_event(KIND_SET_LEVEL, 16'd0, 32'd61);          // zero level drops drive at once
      send_event(KIND_SET_LEVEL, 16'd100, 32'd62);        // level equal to scale
      send_event(KIND_CROSSING, 16'd0, 32'd70);
      send_event(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);   // ignored code, all ones

      // widest scale, zero divider acts as one, 10 ms gap filter across the wrap
      set_phase(16'hFFFF, 8'd0, 8'd10);
      send_event(KIND_SET_LEVEL, 16'hFFFF, 32'd0);        // stores the full 16 bits
      send_event(KIND_CROSSING, 16'd0, 32'hFFFF_FFF8);
      send_event(KIND_CROSSING, 16'd0, 32'hFFFF_FFFC);    // 4 ms, filtered
      send_event(KIND_CROSSING, 16'd0, 32'd2);            // exactly the gap after wrap
      send_event(KIND_CROSSING, 16'd0, 32'd11);           // 9 ms, filtered
      send_event(KIND_CROSSING, 16'd0, 32'd12);           // exactly the gap
      send_event(KIND_SET_LEVEL, 16'd1, 32'd13);
      send_event(KIND_CROSSING, 16'd0, 32'd30);
      mains_ms = 32'd30;

      // random part through several settings; scale drops below the
      // accumulator between phases so the clearing path gets hit
      set_phase(16'd100, 8'd1, 8'd8);
      run_random(200);
      set_phase(16'd1, 8'd2, 8'd0);
      run_random(100);
      set_phase(16'hFFFF, 8'd1, 8'd255);
      run_random(100);
      set_phase(16'd0, 8'd0, 8'd3);                       // zero scale always fires
      run_random(80);
      set_phase(LevelWidth'($urandom_range(2, 300)), 8'd255, 8'd0);
      run_random(120);
      set_phase(16'd7, 8'd3, 8'd10);
      run_random(150);
      set_phase(LevelWidth'($urandom_range(1, 16'hFFFF)), DivWidth'($urandom_range(1, 8)),
                GapWidth'($urandom_range(0, 20)));
      run_random(200);

      settle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
